// ===== hw/rtl/fste_pkg.sv =====
// fste_pkg: shared types, codes and character constants of the text stack executor
// used by the front (lexer), the op queue and the back (stack unit)
package fste_pkg;

  // lexer mode between bytes
  typedef enum logic [1:0] {
    LEX_IDLE  = 2'd0,
    LEX_NUM   = 2'd1,
    LEX_WORD  = 2'd2,
    LEX_MINUS = 2'd3
  } lex_mode_t;

  // progress through the known words
  typedef enum logic [2:0] {
    WS_EMPTY   = 3'd0,
    WS_PLUS    = 3'd1,
    WS_DOT     = 3'd2,
    WS_D       = 3'd3,
    WS_DU      = 3'd4,
    WS_DUP     = 3'd5,
    WS_UNKNOWN = 3'd6
  } word_state_t;

  // word operation handed to the stack unit
  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_PRINT   = 2'd1,
    OP_DUP     = 2'd2,
    OP_UNKNOWN = 2'd3
  } word_op_t;

  // control part of one queue entry: an optional push, then an optional word
  typedef struct packed {
    logic     has_num;
    logic     num_neg;
    logic     has_word;
    word_op_t word;
  } op_entry_t;

  // result kinds and error codes
  localparam logic       RESULT_VALUE  = 1'b0;
  localparam logic       RESULT_ERROR  = 1'b1;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN   = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

  // op queue depth, a power of two
  localparam int QUEUE_DEPTH = 4;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_U     = 8'h75;

  // advance the word matcher by one byte
  function automatic word_state_t word_next(input word_state_t ws, input logic [7:0] b);
    word_state_t r;
    r = WS_UNKNOWN;
    case (ws)
      WS_EMPTY: begin
        if (b == CH_PLUS) r = WS_PLUS;
        else if (b == CH_DOT) r = WS_DOT;
        else if (b == CH_D) r = WS_D;
      end
      WS_D:  if (b == CH_U) r = WS_DU;
      WS_DU: if (b == CH_P) r = WS_DUP;
      default: r = WS_UNKNOWN;
    endcase
    return r;
  endfunction

  // map a completed word to its operation
  function automatic word_op_t word_to_op(input word_state_t ws);
    word_op_t r;
    case (ws)
      WS_PLUS: r = OP_ADD;
      WS_DOT:  r = OP_PRINT;
      WS_DUP:  r = OP_DUP;
      default: r = OP_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/forth_text_stack_executor.sv =====
// forth_text_stack_executor: lexer front, op queue and stack back of a small stack interpreter
// path: a byte's push and word enter the op queue, the stack unit runs them from its head
//   and the result register holds what they produce; earlier queued work delays them
// throughput: one byte per cycle; a byte that both ends a number and completes a word
//   runs as a push, then the word; the op queue absorbs it, input stalls only when full
// reset clears lexer, queue, stack count and halt flag; stack ram contents stay undefined
module forth_text_stack_executor
  import fste_pkg::*;
#(
  parameter int STACK_DEPTH = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         text_byte,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               result_kind,
  output logic signed [31:0] printed_value,
  output logic [1:0]         error_code
);

  logic                   q_full;
  logic                   q_push;
  op_entry_t              q_in_ctl;
  logic [VALUE_WIDTH-1:0] q_in_mag;
  logic                   q_not_empty;
  logic                   q_pop;
  op_entry_t              q_head_ctl;
  logic [VALUE_WIDTH-1:0] q_head_mag;

  // lexer
  fste_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .text_byte (text_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_ctl     (q_in_ctl),
    .q_mag     (q_in_mag)
  );

  // op queue
  fste_queue #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_ctl  (q_in_ctl),
    .push_mag  (q_in_mag),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .head_ctl  (q_head_ctl),
    .head_mag  (q_head_mag)
  );

  // stack unit
  fste_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_not_empty),
    .q_ctl         (q_head_ctl),
    .q_mag         (q_head_mag),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .printed_value (printed_value),
    .error_code    (error_code)
  );

endmodule

// ===== hw/rtl/fste_ram.sv =====
// fste_ram: generic single write port, single read port memory with registered read
// no package dependency
module fste_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/fste_queue.sv =====
// fste_queue: short op queue between the lexer front and the stack back
// depends on fste_pkg for the entry type and depth
module fste_queue
  import fste_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  op_entry_t              push_ctl,
  input  logic [VALUE_WIDTH-1:0] push_mag,
  output logic                   full,
  output logic                   not_empty,
  input  logic                   pop,
  output op_entry_t              head_ctl,
  output logic [VALUE_WIDTH-1:0] head_mag
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  op_entry_t              ctl [QUEUE_DEPTH];
  logic [VALUE_WIDTH-1:0] mag [QUEUE_DEPTH];
  logic [PW-1:0]          wr_ptr;
  logic [PW-1:0]          rd_ptr;
  logic [NW-1:0]          fill;

  assign full      = (fill == NW'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head_ctl  = ctl[rd_ptr];
  assign head_mag  = mag[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ctl[wr_ptr] <= push_ctl;
      mag[wr_ptr] <= push_mag;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= PW'(wr_ptr + 1'b1);
      if (pop)  rd_ptr <= PW'(rd_ptr + 1'b1);
      if (push && !pop) fill <= NW'(fill + 1'b1);
      else if (pop && !push) fill <= NW'(fill - 1'b1);
    end
  end

endmodule

// ===== hw/rtl/fste_front.sv =====
// fste_front: lexer that turns program bytes into push and word operations
// depends on fste_pkg for lexer states, word codes and characters
module fste_front
  import fste_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             text_byte,
  input  logic                   last_byte,
  input  logic                   q_full,
  output logic                   q_push,
  output op_entry_t              q_ctl,
  output logic [VALUE_WIDTH-1:0] q_mag
);

  lex_mode_t              mode, mode_next;
  word_state_t            ws, ws_next;
  logic [VALUE_WIDTH-1:0] acc, acc_next;
  logic                   neg, neg_next;

  logic                   accept;
  logic                   is_digit;
  logic                   is_delim;
  logic [VALUE_WIDTH-1:0] digit_val;
  logic [VALUE_WIDTH-1:0] acc_step;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // byte classes
  assign is_digit  = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
  assign is_delim  = (text_byte == CH_NUL) || (text_byte == CH_SPACE) ||
                     ((text_byte >= CH_TAB) && (text_byte <= CH_CR));
  assign digit_val = VALUE_WIDTH'(text_byte[3:0]);
  // decimal step: times ten as two shifts, plus the new digit
  assign acc_step  = (acc << 3) + (acc << 1) + digit_val;

  // lexer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= LEX_IDLE;
      ws   <= WS_EMPTY;
      acc  <= '0;
      neg  <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      ws   <= ws_next;
      acc  <= acc_next;
      neg  <= neg_next;
    end
  end

  // next lexer state and the operations this byte causes
  always_comb begin
    mode_next = mode;
    ws_next   = ws;
    acc_next  = acc;
    neg_next  = neg;
    q_ctl     = '{has_num: 1'b0, num_neg: 1'b0, has_word: 1'b0, word: OP_UNKNOWN};
    q_mag     = acc;

    // continue or close the pending token
    unique case (mode)
      LEX_NUM: begin
        if (is_digit) begin
          acc_next = acc_step;
        end else begin
          q_ctl.has_num = 1'b1;
          q_ctl.num_neg = neg;
          q_mag         = acc;
          mode_next     = LEX_IDLE;
          acc_next      = '0;
          neg_next      = 1'b0;
        end
      end
      LEX_MINUS: begin
        if (is_digit) begin
          mode_next = LEX_NUM;
          neg_next  = 1'b1;
          acc_next  = digit_val;
        end else begin
          mode_next = LEX_WORD;
          ws_next   = WS_UNKNOWN;
          if (is_delim) begin
            q_ctl.has_word = 1'b1;
            q_ctl.word     = OP_UNKNOWN;
            mode_next      = LEX_IDLE;
            ws_next        = WS_EMPTY;
          end
        end
      end
      LEX_WORD: begin
        if (is_delim) begin
          q_ctl.has_word = 1'b1;
          q_ctl.word     = word_to_op(ws);
          mode_next      = LEX_IDLE;
          ws_next        = WS_EMPTY;
        end else begin
          ws_next = word_next(ws, text_byte);
        end
      end
      LEX_IDLE: begin
      end
    endcase

    // start a new token
    if (mode_next == LEX_IDLE && !is_delim) begin
      if (is_digit) begin
        mode_next = LEX_NUM;
        neg_next  = 1'b0;
        acc_next  = digit_val;
      end else if (text_byte == CH_MINUS) begin
        mode_next = LEX_MINUS;
      end else begin
        mode_next = LEX_WORD;
        ws_next   = word_next(WS_EMPTY, text_byte);
      end
    end

    // final byte closes whatever token is still open
    if (last_byte) begin
      unique case (mode_next)
        LEX_NUM: begin
          q_ctl.has_num = 1'b1;
          q_ctl.num_neg = neg_next;
          q_mag         = acc_next;
          mode_next     = LEX_IDLE;
          acc_next      = '0;
          neg_next      = 1'b0;
        end
        LEX_MINUS: begin
          q_ctl.has_word = 1'b1;
          q_ctl.word     = OP_UNKNOWN;
          mode_next      = LEX_IDLE;
          ws_next        = WS_EMPTY;
        end
        LEX_WORD: begin
          q_ctl.has_word = 1'b1;
          q_ctl.word     = word_to_op(ws_next);
          mode_next      = LEX_IDLE;
          ws_next        = WS_EMPTY;
        end
        LEX_IDLE: begin
        end
      endcase
    end

    q_push = accept && (q_ctl.has_num || q_ctl.has_word);
  end

endmodule

// ===== hw/rtl/fste_back.sv =====
// fste_back: stack unit that runs queued operations and drives the result register
// depends on fste_pkg and fste_ram; top two values live in registers, the rest in ram
module fste_back
  import fste_pkg::*;
#(
  parameter int STACK_DEPTH = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  op_entry_t              q_ctl,
  input  logic [VALUE_WIDTH-1:0] q_mag,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   result_kind,
  output logic signed [31:0]     printed_value,
  output logic [1:0]             error_code
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0]          cnt, cnt_next, cnt_eff, cnt_rd;
  logic [VALUE_WIDTH-1:0] tos, tos_next;
  logic [VALUE_WIDTH-1:0] nos, nos_next;
  logic                   halted, halted_next;
  logic                   second;

  logic                   fwd_hit;
  logic [VALUE_WIDTH-1:0] fwd_data;
  logic [VALUE_WIDTH-1:0] ram_rdata;
  logic [VALUE_WIDTH-1:0] nos_fill;
  logic [CW-1:0]          cnt_wr;
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr;
  logic                   we, ram_we;

  logic                   doing_word;
  logic                   do_push;
  logic [VALUE_WIDTH-1:0] push_val;
  logic [VALUE_WIDTH-1:0] pv;
  logic                   res;
  logic                   res_kind;
  logic [1:0]             res_code;
  logic [VALUE_WIDTH-1:0] res_val;
  logic signed [63:0]     res_ext;
  logic                   out_free;
  logic                   go;

  // spilled stack entries below the top two
  fste_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (nos),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // third entry from the top, with bypass of a same-cycle spill
  assign nos_fill   = fwd_hit ? fwd_data : ram_rdata;
  assign doing_word = !q_ctl.has_num || second;
  assign push_val   = q_ctl.num_neg ? VALUE_WIDTH'('0 - q_mag) : q_mag;
  assign cnt_wr     = CW'(cnt - CW'(2));
  assign waddr      = cnt_wr[AW-1:0];

  // execute the current operation
  always_comb begin
    cnt_next    = cnt;
    tos_next    = tos;
    nos_next    = nos;
    halted_next = halted;
    we          = 1'b0;
    do_push     = 1'b0;
    pv          = push_val;
    res         = 1'b0;
    res_kind    = RESULT_VALUE;
    res_code    = ERR_UNDERFLOW;
    res_val     = '0;

    if (!halted) begin
      if (!doing_word) begin
        do_push = 1'b1;
      end else begin
        unique case (q_ctl.word)
          OP_ADD: begin
            if (cnt < CW'(2)) begin
              res      = 1'b1;
              res_kind = RESULT_ERROR;
              res_code = ERR_UNDERFLOW;
            end else begin
              tos_next = tos + nos;
              nos_next = nos_fill;
              cnt_next = CW'(cnt - 1'b1);
            end
          end
          OP_PRINT: begin
            res = 1'b1;
            if (cnt == '0) begin
              res_kind = RESULT_ERROR;
              res_code = ERR_UNDERFLOW;
            end else begin
              res_val  = tos;
              tos_next = nos;
              nos_next = nos_fill;
              cnt_next = CW'(cnt - 1'b1);
            end
          end
          OP_DUP: begin
            if (cnt == '0) begin
              res      = 1'b1;
              res_kind = RESULT_ERROR;
              res_code = ERR_UNDERFLOW;
            end else begin
              do_push = 1'b1;
              pv      = tos;
            end
          end
          OP_UNKNOWN: begin
            res      = 1'b1;
            res_kind = RESULT_ERROR;
            res_code = ERR_UNKNOWN;
          end
        endcase
      end

      // push spills the second entry to ram
      if (do_push) begin
        if (cnt == CW'(STACK_DEPTH)) begin
          res      = 1'b1;
          res_kind = RESULT_ERROR;
          res_code = ERR_OVERFLOW;
        end else begin
          we       = (cnt >= CW'(2));
          nos_next = tos;
          tos_next = pv;
          cnt_next = CW'(cnt + 1'b1);
        end
      end

      if (res && res_kind == RESULT_ERROR) begin
        halted_next = 1'b1;
      end
    end
  end

  // advance when the result register can take what this op produces
  assign out_free = !out_valid || !out_stall;
  assign go       = q_valid && (!res || out_free);
  assign q_pop    = go && (halted || doing_word || !q_ctl.has_word);
  assign ram_we   = go && we;

  // keep the ram read aimed at the entry under the new second
  assign cnt_eff = go ? cnt_next : cnt;
  assign cnt_rd  = CW'(cnt_eff - CW'(3));
  assign raddr   = cnt_rd[AW-1:0];

  assign res_ext = 64'($signed(res_val));

  // stack state and entry phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      halted  <= 1'b0;
      second  <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= ram_we && (waddr == raddr);
      if (go) begin
        cnt    <= cnt_next;
        halted <= halted_next;
        second <= !q_pop;
      end
    end
  end

  // top two values and bypass data
  always_ff @(posedge clk) begin
    fwd_data <= nos;
    if (go) begin
      tos <= tos_next;
      nos <= nos_next;
    end
  end

  // result register, valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && res) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register, payload
  always_ff @(posedge clk) begin
    if (go && res) begin
      result_kind   <= res_kind;
      printed_value <= res_ext[31:0];
      error_code    <= res_code;
    end
  end

endmodule

// ===== verif/forth_text_stack_executor_test.sv =====
// forth_text_stack_executor_test: self-checking bench for the text stack executor
// streams program text through the byte channel and checks every printed value or error
// depends on fste_pkg and the forth_text_stack_executor top level
module forth_text_stack_executor_test
  import fste_pkg::*;
();

  localparam int STACK_DEPTH   = 256;
  localparam int VALUE_WIDTH   = 32;
  localparam int RANDOM_BYTES  = 150;
  localparam int SHALLOW_LIMIT = 24;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HALT_TAIL     = 32;
  localparam logic [1:0] NO_ERROR = 2'd0;

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
    logic [1:0]  code;
  } result_t;

  typedef struct {
    string   text;
    bit      last;
    bit      typed;
    result_t want;
  } text_row_t;

  typedef enum {TOK_NUM, TOK_ADD, TOK_PRINT, TOK_DUP} token_t;
  typedef enum {END_UNDERFLOW, END_UNKNOWN, END_LONE_MINUS, END_OVERFLOW} ending_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         text_byte;
  logic               last_byte;
  logic               out_valid;
  logic               out_stall;
  logic               result_kind;
  logic signed [31:0] printed_value;
  logic [1:0]         error_code;

  // predicted machine state
  logic [31:0] stack_mem [STACK_DEPTH];
  int          depth_now;
  lex_mode_t   lex_now;
  logic [31:0] num_acc;
  bit          num_neg;
  word_state_t word_now;
  bit          halted;

  result_t pending_results [$];
  result_t no_result;
  int      errors_found;
  int      results_checked;
  int      bytes_taken;
  int      burst_left;
  int      plan_depth;
  bit      glued;

  // directed text; '~' stands for a zero byte
  text_row_t directed_rows [25] = '{
    '{"0 .",                    1'b1, 1'b1, '{RESULT_VALUE, 32'd0,          NO_ERROR}},
    '{"2147483647 .",           1'b1, 1'b1, '{RESULT_VALUE, 32'h7FFF_FFFF,  NO_ERROR}},
    '{"-2147483648 .",          1'b1, 1'b1, '{RESULT_VALUE, 32'h8000_0000,  NO_ERROR}},
    '{"4294967295 .",           1'b1, 1'b1, '{RESULT_VALUE, 32'hFFFF_FFFF,  NO_ERROR}},
    '{"4294967296 .",           1'b1, 1'b1, '{RESULT_VALUE, 32'd0,          NO_ERROR}},
    '{"-0 .",                   1'b1, 1'b1, '{RESULT_VALUE, 32'd0,          NO_ERROR}},
    '{"99999999999999999999 .", 1'b1, 1'b0, '{RESULT_VALUE, 32'd0,          NO_ERROR}},
    '{"-18446744073709551617 .", 1'b1, 1'b0, '{RESULT_VALUE, 32'd0,         NO_ERROR}},
    '{"1 2 + .",                1'b1, 1'b1, '{RESULT_VALUE, 32'd3,          NO_ERROR}},
    '{"2147483647 1 + .",       1'b1, 1'b1, '{RESULT_VALUE, 32'h8000_0000,  NO_ERROR}},
    '{"-1 -1 + .",              1'b1, 1'b1, '{RESULT_VALUE, 32'hFFFF_FFFE,  NO_ERROR}},
    '{"7 dup + .",              1'b1, 1'b1, '{RESULT_VALUE, 32'd14,         NO_ERROR}},
    '{"12.",                    1'b1, 1'b1, '{RESULT_VALUE, 32'd12,         NO_ERROR}},
    '{"5-3 + .",                1'b1, 1'b1, '{RESULT_VALUE, 32'd2,          NO_ERROR}},
    '{"4dup + .",               1'b1, 1'b1, '{RESULT_VALUE, 32'd8,          NO_ERROR}},
    '{"3~4\t+\n.~",             1'b1, 1'b1, '{RESULT_VALUE, 32'd7,          NO_ERROR}},
    '{"\013 8\0159",            1'b1, 1'b0, '{RESULT_VALUE, 32'd0,          NO_ERROR}},
    '{"+\014.\t",               1'b0, 1'b1, '{RESULT_VALUE, 32'd17,         NO_ERROR}},
    '{"12 34 . . ",             1'b0, 1'b0, '{RESULT_VALUE, 32'd0,          NO_ERROR}},
    '{"-7",                     1'b1, 1'b0, '{RESULT_VALUE, 32'd0,          NO_ERROR}},
    '{"dup",                    1'b1, 1'b0, '{RESULT_VALUE, 32'd0,          NO_ERROR}},
    '{"+ .",                    1'b1, 1'b1, '{RESULT_VALUE, 32'hFFFF_FFF2,  NO_ERROR}},
    '{"  \t~ ",                 1'b1, 1'b0, '{RESULT_VALUE, 32'd0,          NO_ERROR}},
    '{"5",                      1'b1, 1'b0, '{RESULT_VALUE, 32'd0,          NO_ERROR}},
    '{"6 + .",                  1'b1, 1'b1, '{RESULT_VALUE, 32'd11,         NO_ERROR}}
  };

  forth_text_stack_executor #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .text_byte     (text_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .printed_value (printed_value),
    .error_code    (error_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_blank(input logic [7:0] b);
    return b == CH_NUL || b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic word_state_t advance_word(input word_state_t ws, input logic [7:0] b);
    case (ws)
      WS_EMPTY: begin
        if (b == CH_PLUS) return WS_PLUS;
        if (b == CH_DOT) return WS_DOT;
        if (b == CH_D) return WS_D;
        return WS_UNKNOWN;
      end
      WS_D:    return (b == CH_U) ? WS_DU : WS_UNKNOWN;
      WS_DU:   return (b == CH_P) ? WS_DUP : WS_UNKNOWN;
      default: return WS_UNKNOWN;
    endcase
  endfunction

  function automatic bit halt_with(input logic [1:0] code, output result_t r);
    halted  = 1'b1;
    lex_now = LEX_IDLE;
    r       = '{RESULT_ERROR, 32'd0, code};
    return 1'b1;
  endfunction

  function automatic bit push_value(input logic [31:0] v, output result_t r);
    if (depth_now >= STACK_DEPTH) return halt_with(ERR_OVERFLOW, r);
    stack_mem[depth_now] = v;
    depth_now++;
    return 1'b0;
  endfunction

  function automatic bit close_number(output result_t r);
    logic [31:0] v;
    v       = num_neg ? 32'd0 - num_acc : num_acc;
    lex_now = LEX_IDLE;
    num_acc = 32'd0;
    num_neg = 1'b0;
    return push_value(v, r);
  endfunction

  function automatic bit close_word(output result_t r);
    word_state_t w;
    w        = word_now;
    lex_now  = LEX_IDLE;
    word_now = WS_EMPTY;
    case (w)
      WS_PLUS: begin
        if (depth_now < 2) return halt_with(ERR_UNDERFLOW, r);
        stack_mem[depth_now-2] = stack_mem[depth_now-1] + stack_mem[depth_now-2];
        depth_now--;
        return 1'b0;
      end
      WS_DOT: begin
        if (depth_now < 1) return halt_with(ERR_UNDERFLOW, r);
        depth_now--;
        r = '{RESULT_VALUE, stack_mem[depth_now], NO_ERROR};
        return 1'b1;
      end
      WS_DUP: begin
        if (depth_now < 1) return halt_with(ERR_UNDERFLOW, r);
        return push_value(stack_mem[depth_now-1], r);
      end
      default: return halt_with(ERR_UNKNOWN, r);
    endcase
  endfunction

  // one text byte through the lexer and stack; returns 1 when a result comes out
  function automatic bit run_text_byte(input logic [7:0] b, input bit fin, output result_t r);
    bit blank;
    blank = is_blank(b);
    if (halted) return 1'b0;
    case (lex_now)
      LEX_NUM: begin
        if (is_digit(b)) num_acc = num_acc * 32'd10 + 32'(b - CH_ZERO);
        else if (close_number(r)) return 1'b1;
      end
      LEX_MINUS: begin
        if (is_digit(b)) begin
          lex_now = LEX_NUM;
          num_neg = 1'b1;
          num_acc = 32'(b - CH_ZERO);
        end else begin
          lex_now  = LEX_WORD;
          word_now = WS_UNKNOWN;
          if (blank) return close_word(r);
        end
      end
      LEX_WORD: begin
        if (blank) begin
          if (close_word(r)) return 1'b1;
        end else begin
          word_now = advance_word(word_now, b);
        end
      end
      default: ;
    endcase
    // a byte seen while idle, or one that ended a number, may open a token
    if (lex_now == LEX_IDLE && !blank) begin
      if (is_digit(b)) begin
        lex_now = LEX_NUM;
        num_neg = 1'b0;
        num_acc = 32'(b - CH_ZERO);
      end else if (b == CH_MINUS) begin
        lex_now = LEX_MINUS;
      end else begin
        lex_now  = LEX_WORD;
        word_now = advance_word(WS_EMPTY, b);
      end
    end
    // final byte completes whatever is pending
    if (fin) begin
      case (lex_now)
        LEX_NUM:   return close_number(r);
        LEX_MINUS: begin
          word_now = WS_UNKNOWN;
          return close_word(r);
        end
        LEX_WORD:  return close_word(r);
        default:   ;
      endcase
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- sender

  // one byte transfer, after a random gap at the start of each burst
  task automatic send_byte(input logic [7:0] b, input bit fin, input bit typed,
                           input result_t want);
    int      gap;
    result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap = 0;
        9:          gap = $urandom_range(10, 20);
        default:    gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    text_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_taken++;
    if (run_text_byte(b, fin, r)) begin
      if (typed) pending_results.push_back(want);
      else pending_results.push_back(r);
    end else if (typed) begin
      pending_results.push_back(want);
    end
  endtask

  task automatic put(input logic [7:0] b, input bit fin);
    send_byte(b, fin, 1'b0, no_result);
  endtask

  function automatic logic [7:0] pick_blank();
    int k;
    k = $urandom_range(0, 7);
    if (k == 0) return CH_NUL;
    if (k >= 6) return CH_SPACE;
    return 8'(CH_TAB + k - 1);
  endfunction

  // one well-formed token that keeps the stack between empty and a shallow ceiling
  task automatic put_token();
    token_t op;
    int     pick;
    int     digits;
    int     n;
    bit     at_end;
    bit     neg;
    do begin
      pick = $urandom_range(0, 99);
      op = (pick < 40) ? TOK_NUM : (pick < 60) ? TOK_ADD : (pick < 85) ? TOK_PRINT : TOK_DUP;
    end while (!((op == TOK_NUM && plan_depth < SHALLOW_LIMIT) ||
                 (op == TOK_ADD && plan_depth >= 2) ||
                 (op == TOK_PRINT && plan_depth >= 1) ||
                 (op == TOK_DUP && plan_depth >= 1 && plan_depth < SHALLOW_LIMIT)));
    at_end = ($urandom_range(0, 6) == 0);
    case (op)
      TOK_NUM: begin
        // a glued number must start with a minus, or the digits would merge
        neg = glued || ($urandom_range(0, 9) < 3);
        if (neg) put(CH_MINUS, 1'b0);
        digits = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
        for (int k = 0; k < digits; k++)
          put(8'(CH_ZERO + $urandom_range(0, 9)), at_end && k == digits - 1);
        plan_depth++;
      end
      TOK_ADD: begin
        put(CH_PLUS, at_end);
        plan_depth--;
      end
      TOK_PRINT: begin
        put(CH_DOT, at_end);
        plan_depth--;
      end
      default: begin
        put(CH_D, 1'b0);
        put(CH_U, 1'b0);
        put(CH_P, at_end);
        plan_depth++;
      end
    endcase
    glued = 1'b0;
    if (!at_end) begin
      if (op == TOK_NUM && $urandom_range(0, 3) == 0) begin
        glued = 1'b1;
      end else begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
        for (int k = 0; k < n; k++)
          put(pick_blank(), k == n - 1 && $urandom_range(0, 9) == 0);
      end
    end
  endtask

  // idle the input until every prediction is matched
  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin
    int stall_mode;
    int mode_left;
    out_stall <= 1'b0;
    mode_left = 0;
    stall_mode = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(5, 60);
      end
      mode_left--;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 1) == 1);
        2:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing predicted: kind %0d value %0d code %0d",
               result_kind, printed_value, error_code);
        errors_found++;
      end else begin
        e = pending_results.pop_front();
        results_checked++;
        if (result_kind !== e.kind) begin
          $error("result_kind: expected %0d, got %0d", e.kind, result_kind);
          errors_found++;
        end
        if (printed_value !== e.value) begin
          $error("printed_value: expected %0d, got %0d", $signed(e.value), printed_value);
          errors_found++;
        end
        if (error_code !== e.code) begin
          $error("error_code: expected %0d, got %0d", e.code, error_code);
          errors_found++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    ending_t    ending;
    logic [7:0] c;
    int         len;
    int         n;
    result_t    fault;

    rst       <= 1'b1;
    in_valid  <= 1'b0;
    text_byte <= 8'd0;
    last_byte <= 1'b0;
    no_result = '{RESULT_VALUE, 32'd0, NO_ERROR};
    errors_found = 0;
    results_checked = 0;
    bytes_taken = 0;
    burst_left = 0;
    glued = 1'b0;
    depth_now = 0;
    lex_now = LEX_IDLE;
    num_acc = 32'd0;
    num_neg = 1'b0;
    word_now = WS_EMPTY;
    halted = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed text rows
    foreach (directed_rows[i]) begin
      len = directed_rows[i].text.len();
      for (int k = 0; k < len; k++) begin
        c = directed_rows[i].text[k];
        if (c == "~") c = CH_NUL;
        send_byte(c, directed_rows[i].last && k == len - 1,
                  directed_rows[i].typed && k == len - 1, directed_rows[i].want);
      end
    end
    wait_all_results();

    // random shallow programs
    plan_depth = depth_now;
    n = bytes_taken + RANDOM_BYTES;
    while (bytes_taken < n) put_token();
    if (glued) put(CH_SPACE, 1'b0);
    glued = 1'b0;

    // fill the stack to the brim with one-byte pushes and dups
    while (plan_depth < STACK_DEPTH) begin
      if (plan_depth > 0 && $urandom_range(0, 3) == 0) begin
        put(CH_D, 1'b0);
        put(CH_U, 1'b0);
        put(CH_P, 1'b1);
      end else begin
        put(8'(CH_ZERO + $urandom_range(0, 9)), 1'b1);
      end
      plan_depth++;
    end
    wait_all_results();

    ending = ending_t'($urandom_range(0, 3));
    if (ending != END_OVERFLOW) begin
      // drain it again with prints and sums
      while (plan_depth > 0) begin
        if (plan_depth >= 2 && $urandom_range(0, 2) == 0) put(CH_PLUS, 1'b1);
        else put(CH_DOT, 1'b1);
        plan_depth--;
      end
    end

    // closing error, after which the block stays halted
    case (ending)
      END_UNDERFLOW: begin
        fault = '{RESULT_ERROR, 32'd0, ERR_UNDERFLOW};
        case ($urandom_range(0, 3))
          0: send_byte(CH_PLUS, 1'b1, 1'b1, fault);
          1: send_byte(CH_DOT, 1'b1, 1'b1, fault);
          2: begin
            put(CH_D, 1'b0);
            put(CH_U, 1'b0);
            send_byte(CH_P, 1'b1, 1'b1, fault);
          end
          default: begin
            put(8'(CH_ZERO + $urandom_range(0, 9)), 1'b1);
            put(CH_PLUS, 1'b0);
            send_byte(pick_blank(), 1'b0, 1'b1, fault);
          end
        endcase
      end
      END_UNKNOWN: begin
        fault = '{RESULT_ERROR, 32'd0, ERR_UNKNOWN};
        len = $urandom_range(1, 5);
        put(8'($urandom_range(128, 255)), 1'b0);
        for (int k = 1; k < len; k++) begin
          do c = 8'($urandom_range(1, 255)); while (is_blank(c));
          put(c, 1'b0);
        end
        send_byte(($urandom_range(0, 1) == 1) ? pick_blank() : CH_SPACE, 1'b0, 1'b1, fault);
      end
      END_LONE_MINUS: begin
        fault = '{RESULT_ERROR, 32'd0, ERR_UNKNOWN};
        case ($urandom_range(0, 2))
          0: send_byte(CH_MINUS, 1'b1, 1'b1, fault);
          1: begin
            put(CH_MINUS, 1'b0);
            send_byte(pick_blank(), 1'b0, 1'b1, fault);
          end
          default: begin
            put(CH_MINUS, 1'b0);
            put(CH_D, 1'b0);
            send_byte(CH_SPACE, 1'b0, 1'b1, fault);
          end
        endcase
      end
      default: begin
        fault = '{RESULT_ERROR, 32'd0, ERR_OVERFLOW};
        if ($urandom_range(0, 1) == 1) begin
          send_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b1, 1'b1, fault);
        end else begin
          put(CH_D, 1'b0);
          put(CH_U, 1'b0);
          send_byte(CH_P, 1'b1, 1'b1, fault);
        end
      end
    endcase

    // halted: arbitrary bytes must be swallowed without results
    put(8'hFF, 1'b1);
    put(CH_NUL, 1'b0);
    for (int k = 2; k < HALT_TAIL; k++)
      put(8'($urandom_range(0, 255)), $urandom_range(0, 1) == 1);

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d text bytes through directed, shallow random and full-stack programs",
             bytes_taken);
    $display("checked %0d results, closing case %s", results_checked, ending.name());
    if (errors_found == 0) begin
      $display("[forth_text_stack_executor] OK");
    end else begin
      $display("[forth_text_stack_executor] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("[forth_text_stack_executor] ERROR");
    $finish;
  end

endmodule
